// ----- hdl/plp_pkg.sv -----
// ----------------------------------------------------------------------------
// plp_pkg - shared types and constants of the positional list
// Request codes, item structs, cell control struct and the sizes that
// follow from the list capacity.
// ----------------------------------------------------------------------------
package plp_pkg;

  localparam int CAPACITY  = 64;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int GROUP_SZ  = 8;
  localparam int N_GROUPS  = (CAPACITY + GROUP_SZ - 1) / GROUP_SZ;
  localparam int VAL_W     = 32;

  localparam logic [1:0] REQ_INS = 2'd0;
  localparam logic [1:0] REQ_DEL = 2'd1;
  localparam logic [1:0] REQ_RD  = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [5:0]               position;
    logic signed [VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic                     ok;
    logic [6:0]               count_after;
    logic signed [VAL_W-1:0]  read_value;
  } out_item_t;

  // Broadcast to every cell in the cycle an item is accepted.
  typedef struct packed {
    logic              ins_en;
    logic              del_en;
    logic              tap_en;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [VAL_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// ----- hdl/plp_cell.sv -----
// ----------------------------------------------------------------------------
// plp_cell - one slot of the list
// Holds one element and moves it to or from its neighbors on insert and
// delete; captures its element into a read tap when its slot is addressed.
// ----------------------------------------------------------------------------
module plp_cell (
  input  logic                        clk,
  input  plp_pkg::cell_ctrl_t         ctrl,
  input  logic [plp_pkg::CNT_W-1:0]   cell_idx,
  input  logic [plp_pkg::VAL_W-1:0]   left_val,
  input  logic [plp_pkg::VAL_W-1:0]   right_val,
  output logic [plp_pkg::VAL_W-1:0]   elem,
  output logic [plp_pkg::VAL_W-1:0]   tap
);

  logic [plp_pkg::VAL_W-1:0] elem_r, elem_nxt;
  logic [plp_pkg::VAL_W-1:0] tap_r, tap_nxt;

  always_comb begin
    elem_nxt = elem_r;
    if (ctrl.ins_en) begin
      if (cell_idx == ctrl.pos) begin
        elem_nxt = ctrl.value;
      end else if (cell_idx > ctrl.pos && cell_idx <= ctrl.count) begin
        elem_nxt = left_val;
      end
    end else if (ctrl.del_en) begin
      if (cell_idx >= ctrl.pos && (cell_idx + plp_pkg::CNT_W'(1)) < ctrl.count) begin
        elem_nxt = right_val;
      end
    end
  end

  always_comb begin
    tap_nxt = tap_r;
    if (ctrl.tap_en) begin
      tap_nxt = (cell_idx == ctrl.pos) ? elem_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    tap_r  <= tap_nxt;
  end

  assign elem = elem_r;
  assign tap  = tap_r;

endmodule

// ----- hdl/plp_rdtree.sv -----
// ----------------------------------------------------------------------------
// plp_rdtree - registered OR tree over the cell read taps
// At most one tap is nonzero; groups are reduced into registers, and the
// group registers are reduced into the final read value.
// ----------------------------------------------------------------------------
module plp_rdtree (
  input  logic                                             clk,
  input  logic                                             ld,
  input  logic [plp_pkg::CAPACITY-1:0][plp_pkg::VAL_W-1:0] taps,
  output logic [plp_pkg::VAL_W-1:0]                        rd_val
);

  logic [plp_pkg::N_GROUPS-1:0][plp_pkg::VAL_W-1:0] grp_r, grp_nxt;

  always_comb begin
    for (int g = 0; g < plp_pkg::N_GROUPS; g++) begin
      grp_nxt[g] = ld ? '0 : grp_r[g];
      if (ld) begin
        for (int k = 0; k < plp_pkg::GROUP_SZ; k++) begin
          if (g * plp_pkg::GROUP_SZ + k < plp_pkg::CAPACITY) begin
            grp_nxt[g] = grp_nxt[g] | taps[g * plp_pkg::GROUP_SZ + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  always_comb begin
    rd_val = '0;
    for (int g = 0; g < plp_pkg::N_GROUPS; g++) begin
      rd_val = rd_val | grp_r[g];
    end
  end

endmodule

// ----- hdl/positional_list_insert_delete_top.sv -----
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top - bounded positional list of values
// Ordered list of signed 32-bit values held in a row of cells, with insert,
// delete and read at a position.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ channel (valid/ready); each item carries a
//   request type, a position and a value. Every item yields exactly one
//   result item on the out_ channel: an ok flag, the element count after
//   the request and, for a successful read, the element read.
//   Insert and delete update the whole row of cells at the edge that
//   accepts the item: past the position (at it, for a delete), every cell
//   takes its neighbor's element at once; an insert writes its value at it.
//   A read captures the addressed cell into its tap at the accept edge;
//   the taps then pass through a two-level registered OR tree.
//   From accept an item passes the read tree step, then the output step,
//   before out_valid; no new item is accepted until it has left them.
//   Reset clears the element count and all handshake state; the stored
//   elements are not cleared and are never read before being written.
//   When the receiver stalls, the result waits in the output register and
//   one more item is still accepted; that item then holds in the last
//   step until the output register frees up.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output plp_pkg::out_item_t  out_data
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_GRP  = 2'd1;
  localparam logic [1:0] PH_OUT  = 2'd2;

  localparam int CW = plp_pkg::CNT_W;

  logic [1:0]     phase_r, phase_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           ok_r, ok_nxt;
  logic           rd_r, rd_nxt;
  logic           out_valid_r, out_valid_nxt;
  plp_pkg::out_item_t out_data_r, out_data_nxt;

  logic           accept;
  logic           acc_ok;
  logic           is_ins, is_del, is_rd;
  logic [6:0]     pos_ext;
  logic [6:0]     cnt_ext;
  logic           out_load;

  plp_pkg::cell_ctrl_t ctrl;
  logic [plp_pkg::CAPACITY-1:0][plp_pkg::VAL_W-1:0] elems;
  logic [plp_pkg::CAPACITY-1:0][plp_pkg::VAL_W-1:0] taps;
  logic [plp_pkg::VAL_W-1:0] rd_val;

  assign in_ready = (phase_r == PH_IDLE);
  assign accept   = in_valid && in_ready;

  // Position and count compared at a common width wide enough for both.
  assign pos_ext = 7'(in_data.position);
  assign cnt_ext = 7'(count_r);

  assign is_ins = (in_data.req_type == plp_pkg::REQ_INS) &&
                  (pos_ext <= cnt_ext) && (count_r < CW'(plp_pkg::CAPACITY));
  assign is_del = (in_data.req_type == plp_pkg::REQ_DEL) && (pos_ext < cnt_ext);
  assign is_rd  = (in_data.req_type == plp_pkg::REQ_RD)  && (pos_ext < cnt_ext);
  assign acc_ok = is_ins || is_del || is_rd;

  // A request position is at most 63, below the capacity, so the cast to
  // the wider count width keeps every bit.
  always_comb begin
    ctrl.ins_en = accept && is_ins;
    ctrl.del_en = accept && is_del;
    ctrl.tap_en = accept && is_rd;
    ctrl.pos    = CW'(in_data.position);
    ctrl.count  = count_r;
    ctrl.value  = in_data.value;
  end

  for (genvar i = 0; i < plp_pkg::CAPACITY; i++) begin : g_cell
    logic [plp_pkg::VAL_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = in_data.value;
    end else begin : g_mid_l
      assign left_v = elems[i-1];
    end
    if (i == plp_pkg::CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = elems[i+1];
    end
    plp_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (CW'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .elem      (elems[i]),
      .tap       (taps[i])
    );
  end

  plp_rdtree u_rdtree (
    .clk    (clk),
    .ld     (phase_r == PH_GRP),
    .taps   (taps),
    .rd_val (rd_val)
  );

  assign out_load = (phase_r == PH_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    ok_nxt        = ok_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          ok_nxt    = acc_ok;
          rd_nxt    = is_rd;
          if (is_ins) begin
            count_nxt = count_r + CW'(1);
          end else if (is_del) begin
            count_nxt = count_r - CW'(1);
          end
          phase_nxt = PH_GRP;
        end
      end
      PH_GRP: begin
        phase_nxt = PH_OUT;
      end
      PH_OUT: begin
        if (out_load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.ok          = ok_r;
          out_data_nxt.count_after = 7'(count_r);
          out_data_nxt.read_value  = rd_r ? rd_val : '0;
          phase_nxt                = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ok_r       <= ok_nxt;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The element count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(plp_pkg::CAPACITY))
    else $error("element count above capacity");

  // An accepted item always moves on to the read tree step.
  a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (phase_r == PH_GRP))
    else $error("accepted item did not advance");

  // A successful insert grows the list by exactly one.
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_ins) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the count");

  // A successful delete shrinks the list by exactly one.
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_del) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("delete did not shrink the count");

endmodule

// ----- tb/plp_list_checker.sv -----
// ----------------------------------------------------------------------------
// plp_list_checker - result checker for the positional list
// Watches both channels of the list. Each accepted request is applied to a
// private copy of the list, and the result it should produce is queued. Each
// accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module plp_list_checker
  import plp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  in_item_t     in_data,
  input  logic         out_valid,
  input  logic         out_ready,
  input  out_item_t    out_data,
  output int unsigned  list_len,
  output int unsigned  outstanding,
  output int unsigned  fail_count
);

  logic signed [VAL_W-1:0] held_vals [CAPACITY];
  int unsigned             held_count;
  out_item_t               expected_results [$];

  initial begin
    held_count  = 0;
    list_len    = 0;
    outstanding = 0;
    fail_count  = 0;
  end

  // Applies one request to the shadow list and returns the result it yields.
  function out_item_t apply_request(in_item_t req);
    out_item_t   res;
    int unsigned pos;
    pos = req.position;
    res = '0;
    case (req.req_type)
      REQ_INS: begin
        if (pos <= held_count && held_count < CAPACITY) begin
          for (int i = held_count; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = req.value;
          held_count++;
          res.ok = 1'b1;
        end
      end
      REQ_DEL: begin
        if (pos < held_count) begin
          for (int i = pos; i + 1 < held_count; i++) held_vals[i] = held_vals[i+1];
          held_count--;
          res.ok = 1'b1;
        end
      end
      REQ_RD: begin
        if (pos < held_count) begin
          res.read_value = held_vals[pos];
          res.ok         = 1'b1;
        end
      end
      default: ;
    endcase
    res.count_after = held_count[6:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t   want;
    int unsigned errs;
    errs = 0;
    if (!rst_n) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      // Results first: a result never belongs to a request taken at the same edge.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, out_data);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.ok !== want.ok) begin
            $display("%0t: ok mismatch, expected %0d, got %0d", $time, want.ok, out_data.ok);
            errs++;
          end
          if (out_data.count_after !== want.count_after) begin
            $display("%0t: count_after mismatch, expected %0d, got %0d",
                     $time, want.count_after, out_data.count_after);
            errs++;
          end
          if (out_data.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %0d, got %0d",
                     $time, want.read_value, out_data.read_value);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_request(in_data));
    end
    fail_count  <= fail_count + errs;
    list_len    <= held_count;
    outstanding <= expected_results.size();
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb - testbench top for the positional list
// Drives requests into the list and stalls the result side, while a checker
// beside the block predicts every result and compares it. A directed opening
// covers the corner cases; random phases then grow, churn and shrink the list.
// ----------------------------------------------------------------------------
module tb;
  import plp_pkg::*;

  // The block ignores request code 3; it has no name in the package.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 1100;
  // Longest correct quiet stretch is a receiver stall plus a sender gap
  // and the pipeline; this is many times that.
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  int unsigned list_len;
  int unsigned outstanding;
  int unsigned fail_count;

  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_insert_delete_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  plp_list_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .list_len    (list_len),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // The receiver runs in modes, each held for a randomly drawn stretch: always
  // ready, short random stalls, and long stalls. A stall length is drawn when
  // it starts, so every stall has a bounded length.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (ready_mode == 1 && $urandom_range(0, 99) < 30) begin
        stall_left <= $urandom_range(1, 3);
      end else if (ready_mode == 2 && $urandom_range(0, 99) < 40) begin
        stall_left <= $urandom_range(5, 30);
      end
    end
  end

  // The watchdog counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic in_item_t make_req(logic [1:0] kind, logic [5:0] pos, logic [31:0] val);
    in_item_t req;
    req.req_type = kind;
    req.position = pos;
    req.value    = val;
    return req;
  endfunction

  // Builds one random request. grow_pct sets the share of inserts; the rest
  // split between deletes and reads. Most positions are legal for the current
  // length, with the ends of the list favored; a few are anywhere at all.
  function automatic in_item_t pick_request(int unsigned grow_pct, int unsigned len);
    in_item_t    req;
    int unsigned roll;
    int unsigned top_pos;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) begin
      req.req_type = REQ_UNUSED;
    end else if (roll < grow_pct) begin
      req.req_type = REQ_INS;
    end else if (roll < grow_pct + (100 - grow_pct) / 2) begin
      req.req_type = REQ_DEL;
    end else begin
      req.req_type = REQ_RD;
    end

    // Legal upper bound: an insert may append, the others must hit an element.
    if (req.req_type == REQ_INS) begin
      top_pos = (len > 63) ? 63 : len;
    end else begin
      top_pos = (len == 0) ? 0 : len - 1;
    end
    roll = $urandom_range(0, 99);
    if (roll < 10 || (req.req_type != REQ_INS && len == 0)) begin
      req.position = 6'($urandom_range(0, 63));
    end else if (roll < 25) begin
      req.position = 6'd0;
    end else if (roll < 40) begin
      req.position = 6'(top_pos);
    end else begin
      req.position = 6'($urandom_range(0, top_pos));
    end

    case ($urandom_range(0, 19))
      0:       req.value = 32'h8000_0000;
      1:       req.value = 32'h7FFF_FFFF;
      2:       req.value = 32'h0000_0000;
      3:       req.value = 32'hFFFF_FFFF;
      default: req.value = $urandom;
    endcase
    return req;
  endfunction

  // Presents one item, called at a falling edge. The sender works in bursts;
  // between bursts valid may drop for a random gap. Within a burst valid stays
  // high and only the payload moves on. Returns at the falling edge after the
  // item was taken.
  task automatic issue(in_item_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned grow_pct;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening. The empty list rejects reads and deletes and any
    // insert past its end; the unused request code changes nothing.
    issue(make_req(REQ_RD,     6'd0,  32'd0));
    issue(make_req(REQ_DEL,    6'd0,  32'd0));
    issue(make_req(REQ_INS,    6'd1,  32'd5));
    issue(make_req(REQ_UNUSED, 6'd0,  32'd9));
    // Build a short list mostly from the value extremes: append twice, insert
    // at the front, insert in the middle, append again.
    issue(make_req(REQ_INS,    6'd0,  32'h8000_0000));
    issue(make_req(REQ_INS,    6'd1,  32'h7FFF_FFFF));
    issue(make_req(REQ_INS,    6'd0,  32'hFFFF_FFFF));
    issue(make_req(REQ_INS,    6'd1,  32'h0000_0000));
    issue(make_req(REQ_INS,    6'd4,  32'd123));
    for (int p = 0; p < 5; p++) issue(make_req(REQ_RD, 6'(p), 32'h5A5A_5A5A));
    // Positions at and far beyond the count are refused.
    issue(make_req(REQ_RD,     6'd5,  32'd0));
    issue(make_req(REQ_RD,     6'd63, 32'd0));
    issue(make_req(REQ_DEL,    6'd63, 32'd0));
    issue(make_req(REQ_INS,    6'd63, 32'd7));
    // Delete from the middle, the end and the front, then read what is left.
    issue(make_req(REQ_DEL,    6'd2,  32'd0));
    issue(make_req(REQ_DEL,    6'd3,  32'd0));
    issue(make_req(REQ_DEL,    6'd0,  32'd0));
    issue(make_req(REQ_RD,     6'd0,  32'd0));
    issue(make_req(REQ_RD,     6'd1,  32'd0));
    issue(make_req(REQ_UNUSED, 6'd63, 32'hFFFF_FFFF));

    // Random phases. The first one fills the list so that a full list and
    // the high positions are reached early; later phases grow, churn or
    // drain it at random.
    sent = 0;
    phase_len = 150;
    grow_pct = 80;
    while (sent < RANDOM_ITEMS) begin
      repeat (phase_len) begin
        issue(pick_request(grow_pct, list_len));
        sent++;
      end
      phase_len = $urandom_range(30, 120);
      case ($urandom_range(0, 2))
        0:       grow_pct = 75;
        1:       grow_pct = 45;
        default: grow_pct = 15;
      endcase
    end

    // Drain: every expected result must arrive, then the block must stay
    // quiet for DRAIN_CYCLES. The watchdog bounds both waits.
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
